>>> rtl/assert_macros.svh
// Assertion macros for the hashed page table RTL.
// Depends on nothing. Users must provide clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define HPT_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("%m: check failed");
`define HPT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define HPT_ASSERT(lbl, prop)
`define HPT_NEVER(lbl, cond)
`endif
`endif

>>> rtl/hpt_pkg.sv
// Shared types and codes for the hashed page table.
// Depends on nothing; imported by hpt_bucket, hashed_page_table_unit, hpt_checker and testbench.
package hpt_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_DELETE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MOD,
		S_EXEC,
		S_CLEAR
	} state_t;

	typedef struct packed {
		logic    wr_en;
		status_t status;
	} bucket_ctl_t;

endpackage

>>> rtl/hashed_page_table_unit.sv
// Hashed page table: ROWS rows of WAYS packed entries and their valid bits in one
// row-wide synchronous memory. Depends on hpt_pkg, hpt_bucket and assert_macros.svh.
// Power-of-two ROWS: the row is read when the request is accepted, then compared and
// written back in S_EXEC; done is registered from S_EXEC, and no new request is taken
// before S_EXEC ends. Other ROWS first reduce the page in S_MOD, 4 page bits per cycle.
// Reset starts a clearing pass over all ROWS with busy high; results cannot stall.
`include "assert_macros.svh"
module hashed_page_table_unit #(
	parameter int ROWS       = 64,
	parameter int WAYS       = 4,
	parameter int PAGE_BITS  = 20,
	parameter int FRAME_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  operation,
	input  logic [PAGE_BITS-1:0]        page_number,
	input  logic [FRAME_BITS-1:0]       frame_number,
	output logic                        done,
	output logic [1:0]                  status,
	output logic [FRAME_BITS-1:0]       found_frame,
	output logic [$clog2(ROWS)-1:0]     row_index
);
	import hpt_pkg::*;

	localparam int  ROW_BITS = $clog2(ROWS);
	localparam int  EW       = PAGE_BITS + FRAME_BITS;
	localparam int  WW       = WAYS * EW;
	localparam int  MW       = WW + WAYS;
	localparam int  DIG      = 4;
	localparam int  NCH      = (PAGE_BITS + DIG - 1) / DIG;
	localparam int  PW       = NCH * DIG;
	localparam int  YW       = ROW_BITS + DIG;
	localparam int  CNT_W    = (NCH > 1) ? $clog2(NCH) : 1;
	localparam bit  POW2     = (ROWS & (ROWS - 1)) == 0;

	state_t                state_q, state_d;
	logic [1:0]            op_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic [ROW_BITS-1:0]   row_q;
	logic [ROW_BITS-1:0]   rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [ROW_BITS-1:0]   clr_q;
	logic [MW-1:0]         mem_q [ROWS];
	logic [MW-1:0]         rd_word_q;
	logic                  done_q;
	logic [1:0]            status_q;
	logic [FRAME_BITS-1:0] found_q;

	logic                  accept;
	logic                  issue;
	logic                  exec;
	logic                  clear;
	logic [ROW_BITS-1:0]   rd_addr;
	logic [PW-1:0]         page_pad;
	logic [YW-1:0]         rem_y, rem_sub, rem_next;
	logic [WW-1:0]         row_word;
	logic [WAYS-1:0]       valid_row;
	logic [WW-1:0]         new_word;
	logic [WAYS-1:0]       new_valid;
	logic [FRAME_BITS-1:0] found;
	bucket_ctl_t           ctl;

	assign accept    = start && !busy;
	assign page_pad  = PW'(page_q);
	assign rem_y     = {rem_q, page_pad[{cnt_q, 2'b00} +: DIG]};
	assign rem_next  = rem_y - rem_sub;
	assign row_word  = rd_word_q[WW-1:0];
	assign valid_row = rd_word_q[MW-1:WW];

	// The partial remainder takes one page digit per cycle, most significant first.
	always_comb begin
		rem_sub = '0;
		for (int k = 1; k < (1 << DIG); k++) begin
			if (rem_y >= YW'(k * ROWS)) begin
				rem_sub = YW'(k * ROWS);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == ROW_BITS'(ROWS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = POW2 ? S_EXEC : S_MOD;
				end
			end
			S_MOD: begin
				if (cnt_q == '0) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy    = 1'b1;
		issue   = 1'b0;
		exec    = 1'b0;
		clear   = 1'b0;
		rd_addr = rem_next[ROW_BITS-1:0];
		unique case (state_q)
			S_CLEAR: begin
				clear = 1'b1;
			end
			S_IDLE: begin
				busy    = 1'b0;
				issue   = accept && POW2;
				rd_addr = page_number[ROW_BITS-1:0];
			end
			S_MOD: begin
				issue = cnt_q == '0;
			end
			S_EXEC: begin
				exec = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	hpt_bucket #(
		.WAYS       (WAYS),
		.PAGE_BITS  (PAGE_BITS),
		.FRAME_BITS (FRAME_BITS)
	) u_bucket (
		.op        (op_q),
		.page      (page_q),
		.frame     (frame_q),
		.row_word  (row_word),
		.valid     (valid_row),
		.new_word  (new_word),
		.new_valid (new_valid),
		.found     (found),
		.ctl       (ctl)
	);

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_word_q <= mem_q[rd_addr];
		end
		if (clear) begin
			mem_q[clr_q] <= '0;
		end else if (exec && ctl.wr_en) begin
			mem_q[row_q] <= {new_valid, new_word};
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			page_q  <= page_number;
			frame_q <= frame_number;
			rem_q   <= '0;
			cnt_q   <= CNT_W'(NCH - 1);
			if (POW2) begin
				row_q <= page_number[ROW_BITS-1:0];
			end
		end else if (state_q == S_MOD) begin
			rem_q <= rem_next[ROW_BITS-1:0];
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				row_q <= rem_next[ROW_BITS-1:0];
			end
		end
		if (exec) begin
			status_q <= ctl.status;
			found_q  <= found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= exec;
			if (clear) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_frame = found_q;
	assign row_index   = row_q;

	`HPT_ASSERT(a_done_after_exec, done |-> $past(state_q == S_EXEC))
	`HPT_NEVER(a_full_only_insert, done && status == STAT_FULL && op_q != OP_INSERT)
	`HPT_NEVER(a_frame_only_lookup, done && found_frame != '0 && op_q != OP_LOOKUP)
	`HPT_NEVER(a_no_accept_busy, accept && state_q != S_IDLE)

endmodule

>>> rtl/hpt_bucket.sv
// Bucket update logic: compares all ways of one row and builds the new row.
// Depends on hpt_pkg.
module hpt_bucket #(
	parameter int WAYS       = 4,
	parameter int PAGE_BITS  = 20,
	parameter int FRAME_BITS = 16
) (
	input  logic [1:0]                             op,
	input  logic [PAGE_BITS-1:0]                   page,
	input  logic [FRAME_BITS-1:0]                  frame,
	input  logic [WAYS*(PAGE_BITS+FRAME_BITS)-1:0] row_word,
	input  logic [WAYS-1:0]                        valid,
	output logic [WAYS*(PAGE_BITS+FRAME_BITS)-1:0] new_word,
	output logic [WAYS-1:0]                        new_valid,
	output logic [FRAME_BITS-1:0]                  found,
	output hpt_pkg::bucket_ctl_t                   ctl
);
	import hpt_pkg::*;

	localparam int EW   = PAGE_BITS + FRAME_BITS;
	localparam int WIDX = (WAYS > 1) ? $clog2(WAYS) : 1;

	logic [EW-1:0]         ent [WAYS+1];
	logic [WAYS-1:0]       match;
	logic [WAYS-1:0]       prev;
	logic [WIDX-1:0]       hit;
	logic [FRAME_BITS-1:0] hit_frame;
	logic                  hit_any;
	logic                  full;

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			ent[w]   = row_word[w*EW +: EW];
			match[w] = valid[w] && (ent[w][EW-1:FRAME_BITS] == page);
		end
		ent[WAYS] = '0;
		prev[0] = 1'b1;
		for (int w = 1; w < WAYS; w++) begin
			prev[w] = valid[w-1];
		end
		hit       = '0;
		hit_frame = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit       = WIDX'(w);
				hit_frame = ent[w][FRAME_BITS-1:0];
			end
		end
		hit_any = |match;
		full    = valid[WAYS-1];
	end

	always_comb begin
		new_word   = row_word;
		new_valid  = valid;
		found      = '0;
		ctl.wr_en  = 1'b0;
		ctl.status = STAT_MISS;
		case (op)
			OP_INSERT: begin
				if (full) begin
					ctl.status = STAT_FULL;
				end else begin
					ctl.status = STAT_OK;
					ctl.wr_en  = 1'b1;
					new_valid  = (valid << 1) | WAYS'(1);
					for (int w = 0; w < WAYS; w++) begin
						if (!valid[w] && prev[w]) begin
							new_word[w*EW +: EW] = {page, frame};
						end
					end
				end
			end
			OP_LOOKUP: begin
				if (hit_any) begin
					ctl.status = STAT_OK;
					found      = hit_frame;
				end
			end
			OP_DELETE: begin
				if (hit_any) begin
					ctl.status = STAT_OK;
					ctl.wr_en  = 1'b1;
					new_valid  = valid >> 1;
					for (int w = 0; w < WAYS; w++) begin
						if (WIDX'(w) >= hit) begin
							new_word[w*EW +: EW] = ent[w+1];
						end
					end
				end
			end
			default: begin
				ctl.status = STAT_MISS;
			end
		endcase
	end

endmodule

>>> sim/hpt_checker.sv
// Checker for the hashed page table: watches the request and reply channels,
// predicts each reply from its own copy of the table, and counts failures.
// Depends on hpt_pkg for the operation and status codes.
`timescale 1ns / 1ps
module hpt_checker #(
	parameter int ROWS       = 64,
	parameter int WAYS       = 4,
	parameter int PAGE_BITS  = 20,
	parameter int FRAME_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    busy,
	input  logic [1:0]              operation,
	input  logic [PAGE_BITS-1:0]    page_number,
	input  logic [FRAME_BITS-1:0]   frame_number,
	input  logic                    done,
	input  logic [1:0]              status,
	input  logic [FRAME_BITS-1:0]   found_frame,
	input  logic [$clog2(ROWS)-1:0] row_index,
	output int                      failures,
	output int                      accepted,
	output int                      replied
);
	import hpt_pkg::*;

	localparam int SLOTS = ROWS * WAYS;
	localparam int ROW_BITS = $clog2(ROWS);

	typedef struct {
		status_t               status;
		logic [FRAME_BITS-1:0] frame;
		logic [ROW_BITS-1:0]   row;
	} reply_t;

	logic                  slot_valid [SLOTS];
	logic [PAGE_BITS-1:0]  slot_page  [SLOTS];
	logic [FRAME_BITS-1:0] slot_frame [SLOTS];
	reply_t                expected_replies [$];

	task automatic apply_page_request(input logic [1:0] op, input logic [PAGE_BITS-1:0] pg,
			input logic [FRAME_BITS-1:0] fr, output reply_t r);
		int row;
		int base;
		int fill;
		int hit;
		row = int'(pg % ROWS);
		base = row * WAYS;
		fill = 0;
		while (fill < WAYS && slot_valid[base + fill])
			fill++;
		hit = WAYS;
		for (int w = WAYS - 1; w >= 0; w--)
			if (slot_valid[base + w] && slot_page[base + w] == pg)
				hit = w;
		r.status = STAT_MISS;
		r.frame = '0;
		r.row = ROW_BITS'(row);
		case (op)
			OP_INSERT: begin
				if (fill < WAYS) begin
					slot_valid[base + fill] = 1'b1;
					slot_page[base + fill] = pg;
					slot_frame[base + fill] = fr;
					r.status = STAT_OK;
				end else begin
					r.status = STAT_FULL;
				end
			end
			OP_LOOKUP: begin
				if (hit < WAYS) begin
					r.frame = slot_frame[base + hit];
					r.status = STAT_OK;
				end
			end
			OP_DELETE: begin
				if (hit < WAYS) begin
					for (int w = hit; w + 1 < fill; w++) begin
						slot_page[base + w] = slot_page[base + w + 1];
						slot_frame[base + w] = slot_frame[base + w + 1];
					end
					slot_valid[base + fill - 1] = 1'b0;
					r.status = STAT_OK;
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++)
				slot_valid[i] = 1'b0;
			expected_replies.delete();
			failures <= 0;
			accepted <= 0;
			replied <= 0;
		end else begin
			// Replies are checked before a request of the same edge is queued.
			if (done) begin
				if (expected_replies.size() == 0) begin
					if (failures < 10)
						$display("%0t: reply with no request waiting", $time);
					failures <= failures + 1;
				end else begin
					want = expected_replies.pop_front();
					replied <= replied + 1;
					if (status !== want.status || found_frame !== want.frame ||
							row_index !== want.row) begin
						if (failures < 10)
							$display("%0t: mismatch status %0d/%0d frame %h/%h row %0d/%0d %s",
								$time, want.status, status, want.frame, found_frame,
								want.row, row_index, "(expected/actual)");
						failures <= failures + 1;
					end
				end
			end
			if (start && !busy) begin
				apply_page_request(operation, page_number, frame_number, want);
				expected_replies.push_back(want);
				accepted <= accepted + 1;
			end
		end
	end

endmodule

>>> sim/testbench.sv
// Top of the hashed page table testbench: clock, reset, directed and random
// requests with idle bursts, and the verdict. Depends on hpt_pkg, the
// hashed_page_table_unit RTL and hpt_checker.
`timescale 1ns / 1ps
module testbench;
	import hpt_pkg::*;

	localparam int ROWS = 64;
	localparam int WAYS = 4;
	localparam int PAGE_BITS = 20;
	localparam int FRAME_BITS = 16;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 100000;
	localparam int RANDOM_REQUESTS = 600;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	logic [1:0]              operation = '0;
	logic [PAGE_BITS-1:0]    page_number = '0;
	logic [FRAME_BITS-1:0]   frame_number = '0;
	logic                    done;
	logic [1:0]              status;
	logic [FRAME_BITS-1:0]   found_frame;
	logic [$clog2(ROWS)-1:0] row_index;
	int                      failures;
	int                      accepted;
	int                      replied;
	int                      cycles = 0;
	int                      op_count [4] = '{0, 0, 0, 0};
	logic [13:0]             tag_pool [4];

	hashed_page_table_unit #(
		.ROWS(ROWS), .WAYS(WAYS), .PAGE_BITS(PAGE_BITS), .FRAME_BITS(FRAME_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .page_number(page_number), .frame_number(frame_number),
		.done(done), .status(status), .found_frame(found_frame), .row_index(row_index)
	);

	hpt_checker #(
		.ROWS(ROWS), .WAYS(WAYS), .PAGE_BITS(PAGE_BITS), .FRAME_BITS(FRAME_BITS)
	) checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .page_number(page_number), .frame_number(frame_number),
		.done(done), .status(status), .found_frame(found_frame), .row_index(row_index),
		.failures(failures), .accepted(accepted), .replied(replied)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[hashed_page_table_unit] ERROR");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic issue(input logic [1:0] op, input logic [PAGE_BITS-1:0] pg,
			input logic [FRAME_BITS-1:0] fr);
		operation <= op;
		page_number <= pg;
		frame_number <= fr;
		start <= 1'b1;
		op_count[op]++;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic idle(input int gap);
		start <= 1'b0;
		repeat (gap) begin
			operation <= 2'($urandom);
			page_number <= PAGE_BITS'($urandom);
			frame_number <= FRAME_BITS'($urandom);
			@(negedge clk);
		end
	endtask

	task automatic issue_random();
		logic [1:0]           op;
		logic [PAGE_BITS-1:0] pg;
		int                   pick;
		pick = $urandom_range(0, 99);
		if (pick < 38)
			op = OP_INSERT;
		else if (pick < 68)
			op = OP_LOOKUP;
		else if (pick < 95)
			op = OP_DELETE;
		else
			op = OP_UNUSED;
		// Most pages come from a few tags in a few rows so rows fill and match.
		if ($urandom_range(0, 99) < 85)
			pg = {tag_pool[$urandom_range(0, 3)], 6'($urandom_range(0, 5) * 11)};
		else
			pg = PAGE_BITS'($urandom);
		issue(op, pg, FRAME_BITS'($urandom));
	endtask

	initial begin
		for (int i = 0; i < 4; i++)
			tag_pool[i] = 14'($urandom);
		tag_pool[0] = '0;
		tag_pool[3] = '1;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		issue(OP_INSERT, 20'h00000, 16'h0000);
		issue(OP_INSERT, 20'hFFFFF, 16'hFFFF);
		issue(OP_LOOKUP, 20'h00000, 16'hFFFF);
		issue(OP_LOOKUP, 20'hFFFFF, 16'h0000);
		issue(OP_LOOKUP, 20'h00040, 16'h1234);
		issue(OP_INSERT, 20'h00005, 16'h1111);
		issue(OP_INSERT, 20'h12345, 16'h2222);
		idle(3);
		issue(OP_INSERT, 20'h00005, 16'h3333);
		issue(OP_INSERT, 20'hAAA85, 16'h4444);
		issue(OP_INSERT, 20'h00045, 16'h5555);
		issue(OP_LOOKUP, 20'h00005, 16'h0000);
		issue(OP_DELETE, 20'h00005, 16'h0000);
		issue(OP_LOOKUP, 20'h00005, 16'h0000);
		issue(OP_LOOKUP, 20'hAAA85, 16'h0000);
		issue(OP_INSERT, 20'h00045, 16'h5555);
		issue(OP_DELETE, 20'h12345, 16'h0000);
		issue(OP_DELETE, 20'h12345, 16'h0000);
		issue(OP_UNUSED, 20'h00005, 16'hFFFF);
		issue(OP_UNUSED, 20'hFFFFF, 16'h8000);
		issue(OP_DELETE, 20'hFFFFF, 16'h0000);
		issue(OP_LOOKUP, 20'hFFFFF, 16'h0000);
		issue(OP_DELETE, 20'h00000, 16'h0000);
		issue(OP_INSERT, 20'h80000, 16'h8000);
		issue(OP_LOOKUP, 20'h80000, 16'h0000);

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			issue_random();
			if (i == RANDOM_REQUESTS / 2) begin
				start <= 1'b0;
				while (accepted != replied)
					@(negedge clk);
			end else if (i < RANDOM_REQUESTS - 100 && (i / 50) % 3 != 2 &&
					$urandom_range(0, 99) < 25) begin
				idle($urandom_range(1, 10));
			end
		end
		start <= 1'b0;
		while (accepted != replied)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("Covered %0d inserts, %0d lookups, %0d deletes and %0d unused-code requests.",
			op_count[OP_INSERT], op_count[OP_LOOKUP], op_count[OP_DELETE], op_count[OP_UNUSED]);
		$display("Checked %0d replies against the predicted table; %0d failures.",
			replied, failures);
		if (failures == 0 && accepted == replied) begin
			$display("[hashed_page_table_unit] OK");
		end else begin
			$display("[hashed_page_table_unit] ERROR");
		end
		$finish;
	end

endmodule
